[sv/swe_pkg.sv]
// Shared constants for the sliding-window extreme unit.
`timescale 1ns / 1ps
package swe_pkg;

  // Default sizing
  localparam int MAX_WINDOW_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 32;

  // Configuration port
  localparam int WINDOW_SIZE_W = 7;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = WINDOW_SIZE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIND_MINIMUM = 1'd1;

  localparam logic [WINDOW_SIZE_W-1:0] WINDOW_SIZE_RST = 7'd1;

endpackage

[sv/swe_in_if.sv]
// Input channel: sample beats with a restart flag.
`timescale 1ns / 1ps
interface swe_in_if #(
  parameter int SAMPLE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink   (input valid, input sample, input restart, output ready);
endinterface

[sv/swe_out_if.sv]
// Output channel: window extreme beats.
`timescale 1ns / 1ps
interface swe_out_if #(
  parameter int SAMPLE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] window_extreme;

  modport source (output valid, output window_extreme, input ready);
  modport sink   (input valid, input window_extreme, output ready);
endinterface

[sv/swe_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module swe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/sliding_window_extreme_unit.sv]
// Sliding-window maximum / minimum over a stream of signed samples.
`timescale 1ns / 1ps
// The unit keeps a monotonic deque of candidates (value and position) in one
// RAM of MAX_WINDOW entries; the head and tail candidates are mirrored in
// registers so that each compare works on a register, and every drop that
// leaves the deque non-empty reloads the next candidate through the single
// RAM read port. Each sample passes through the head drops, the tail drops
// and the push; each drop waits for its RAM read unless it empties the
// deque. On average each sample causes at most one drop. A new sample is
// accepted while the previous result still waits in the output register;
// the unit stalls before its push only if a new result is due and that
// register is still full and not being taken. window_size (0 acts as 1,
// values above MAX_WINDOW act as MAX_WINDOW) and find_minimum are to be
// written through the configuration port while the unit is idle; the unit
// itself does not enforce this. A result beat is emitted once window_size
// samples have arrived since the last restart.
module sliding_window_extreme_unit
  import swe_pkg::*;
#(
  parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  swe_in_if.sink                in_i,
  swe_out_if.source             out_o
);

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int KW = $clog2(MAX_WINDOW + 1);
  localparam int PW = $clog2(2 * MAX_WINDOW);
  localparam int EW = (KW > WINDOW_SIZE_W) ? KW : WINDOW_SIZE_W;
  localparam int SW = SAMPLE_WIDTH;
  localparam int MW = SW + PW;

  localparam logic [AW-1:0]   IDX_LAST = AW'(MAX_WINDOW - 1);
  localparam logic [PW-1:0]   POS_LAST = PW'(2 * MAX_WINDOW - 1);
  localparam logic [PW:0]     POS_MOD  = (PW+1)'(2 * MAX_WINDOW);
  localparam logic [KW-1:0]   OCC_FULL = KW'(MAX_WINDOW);
  localparam logic [EW-1:0]   WIN_MAX  = EW'(MAX_WINDOW);

  // Sequencer codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_HEAD  = 3'd1;
  localparam logic [2:0] ST_HLOAD = 3'd2;
  localparam logic [2:0] ST_TAIL  = 3'd3;
  localparam logic [2:0] ST_TLOAD = 3'd4;
  localparam logic [2:0] ST_PUSH  = 3'd5;

  function automatic logic [AW-1:0] idx_next(input logic [AW-1:0] idx);
    return (idx == IDX_LAST) ? '0 : idx + AW'(1);
  endfunction

  function automatic logic [AW-1:0] idx_prev(input logic [AW-1:0] idx);
    return (idx == '0) ? IDX_LAST : idx - AW'(1);
  endfunction

  // Control state
  logic [2:0]               state_q, state_d;
  logic [AW-1:0]            head_q, head_d;
  logic [AW-1:0]            tail_q, tail_d;
  logic [KW-1:0]            occ_q, occ_d;
  logic [PW-1:0]            pos_q, pos_d;
  logic [KW-1:0]            seen_q, seen_d;
  logic                     out_valid_q, out_valid_d;
  logic [WINDOW_SIZE_W-1:0] win_q;
  logic                     fmin_q;

  // Payload state
  logic signed [SW-1:0] smp_q, smp_d;
  logic signed [SW-1:0] hval_q, hval_d;
  logic [PW-1:0]        hpos_q, hpos_d;
  logic signed [SW-1:0] tval_q, tval_d;
  logic signed [SW-1:0] out_data_q, out_data_d;

  // RAM port signals
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [MW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [MW-1:0] ram_rdata;
  logic signed [SW-1:0] rd_val;
  logic [PW-1:0]        rd_pos;

  // Derived values
  logic [EW-1:0] win_ext;
  logic [EW-1:0] k_ext;
  logic [KW-1:0] k;
  logic [PW:0]   age;
  logic          head_stale;
  logic          dominated;
  logic [KW-1:0] seen_inc;
  logic          emit;
  logic          push_go;
  logic [AW-1:0] tail_prev;

  swe_ram #(
    .WIDTH (MW),
    .DEPTH (MAX_WINDOW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_val = ram_rdata[MW-1:PW];
  assign rd_pos = ram_rdata[PW-1:0];

  // Clamp the window length to 1..MAX_WINDOW
  assign win_ext = EW'(win_q);
  assign k_ext   = (win_ext == '0) ? EW'(1) : ((win_ext > WIN_MAX) ? WIN_MAX : win_ext);
  assign k       = k_ext[KW-1:0];

  // Age of the head candidate, modulo twice the maximum window
  assign age = (pos_q >= hpos_q) ? ({1'b0, pos_q} - {1'b0, hpos_q})
                                 : ({1'b0, pos_q} + POS_MOD - {1'b0, hpos_q});
  assign head_stale = (age >= (PW+1)'(k));

  // Tail candidate loses against the new sample; equal values stay
  assign dominated = fmin_q ? (tval_q > smp_q) : (tval_q < smp_q);

  assign seen_inc = (seen_q < k) ? seen_q + KW'(1) : seen_q;
  assign emit     = (seen_inc >= k);
  assign push_go  = !emit || !out_valid_q || out_o.ready;
  assign tail_prev = idx_prev(tail_q);

  assign in_i.ready           = (state_q == ST_IDLE);
  assign out_o.valid          = out_valid_q;
  assign out_o.window_extreme = out_data_q;

  // Sequencer: head drops, tail drops, then push and result
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    occ_d       = occ_q;
    pos_d       = pos_q;
    seen_d      = seen_q;
    smp_d       = smp_q;
    hval_d      = hval_q;
    hpos_d      = hpos_q;
    tval_d      = tval_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_o.ready;
    ram_we      = 1'b0;
    ram_waddr   = tail_q;
    ram_wdata   = {smp_q, pos_q};
    ram_re      = 1'b0;
    ram_raddr   = head_q;

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          smp_d = in_i.sample;
          if (in_i.restart) begin
            head_d = '0;
            tail_d = '0;
            occ_d  = '0;
            pos_d  = '0;
            seen_d = '0;
          end
          state_d = ST_HEAD;
        end
      end
      ST_HEAD: begin
        // Drop the head once it has left the window, reload the next one
        if (occ_q != '0 && head_stale) begin
          head_d = idx_next(head_q);
          occ_d  = occ_q - KW'(1);
          if (occ_q != KW'(1)) begin
            ram_re    = 1'b1;
            ram_raddr = idx_next(head_q);
            state_d   = ST_HLOAD;
          end
        end else begin
          state_d = ST_TAIL;
        end
      end
      ST_HLOAD: begin
        hval_d  = rd_val;
        hpos_d  = rd_pos;
        state_d = ST_HEAD;
      end
      ST_TAIL: begin
        // Drop a dominated tail, reload the one before it
        if (occ_q != '0 && dominated) begin
          tail_d = tail_prev;
          occ_d  = occ_q - KW'(1);
          if (occ_q != KW'(1)) begin
            ram_re    = 1'b1;
            ram_raddr = idx_prev(tail_prev);
            state_d   = ST_TLOAD;
          end
        end else begin
          state_d = ST_PUSH;
        end
      end
      ST_TLOAD: begin
        tval_d  = rd_val;
        state_d = ST_TAIL;
      end
      ST_PUSH: begin
        // Append the sample; hold while a due result cannot be stored
        if (push_go) begin
          ram_we = 1'b1;
          tail_d = idx_next(tail_q);
          occ_d  = occ_q + KW'(1);
          tval_d = smp_q;
          if (occ_q == '0) begin
            hval_d = smp_q;
            hpos_d = pos_q;
          end
          pos_d  = (pos_q == POS_LAST) ? '0 : pos_q + PW'(1);
          seen_d = seen_inc;
          if (emit) begin
            out_valid_d = 1'b1;
            out_data_d  = (occ_q == '0) ? smp_q : hval_q;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      pos_q       <= '0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      occ_q       <= occ_d;
      pos_q       <= pos_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= WINDOW_SIZE_RST;
      fmin_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WINDOW_SIZE:  win_q  <= cfg_data_i[WINDOW_SIZE_W-1:0];
        CFG_FIND_MINIMUM: fmin_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    smp_q      <= smp_d;
    hval_q     <= hval_d;
    hpos_q     <= hpos_d;
    tval_q     <= tval_d;
    out_data_q <= out_data_d;
  end

  // The deque never fills: every candidate is younger than the window
  a_no_full_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PUSH |-> occ_q < OCC_FULL)
    else $error("deque full at push");

  // An empty deque has its pointers together
  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && occ_q == '0) |-> tail_q == head_q)
    else $error("empty deque with split pointers");

  // A restart beat empties the deque and the counts
  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.restart) |=> (occ_q == '0 && seen_q == '0))
    else $error("restart did not clear the deque");

  // A result is loaded only on the push step
  a_result_on_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q && state_q != ST_PUSH) |=> !out_valid_q)
    else $error("result raised outside the push step");

endmodule

[tb/sv/swe_extreme_checker.sv]
// Checker for the sliding-window extreme unit: tracks the window and scores result beats.
`timescale 1ns / 1ps
module swe_extreme_checker
  import swe_pkg::*;
#(
  parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  swe_in_if                     smp_ch_i,
  swe_out_if                    ext_ch_i,
  output int                    fail_cnt_o,
  output int                    pending_o,
  output int                    checked_o
);
  localparam int PTR_W        = $clog2(MAX_WINDOW);
  localparam int POS_W        = PTR_W + 1;
  localparam int REPORT_LIMIT = 10;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  // Candidate deque: values with the position at which each arrived
  sample_t                  cand_val [MAX_WINDOW];
  logic [POS_W-1:0]         cand_pos [MAX_WINDOW];
  logic [PTR_W-1:0]         head_ptr;
  logic [PTR_W-1:0]         tail_ptr;
  logic [POS_W-1:0]         occupancy;
  logic [POS_W-1:0]         pos_ctr;
  logic [POS_W-1:0]         seen_cnt;
  logic [WINDOW_SIZE_W-1:0] win_len;
  logic                     track_min;

  sample_t extremes_due[$];
  int      fail_cnt;
  int      checked;

  function automatic void clear_window();
    head_ptr  = '0;
    tail_ptr  = '0;
    occupancy = '0;
    pos_ctr   = '0;
    seen_cnt  = '0;
  endfunction

  // Advance the window by one sample; return 1 when a result beat is due.
  function automatic bit slide_window(input sample_t smp, input logic new_seq,
                                      output sample_t extreme);
    logic [POS_W-1:0] span;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] age;
    logic [PTR_W-1:0] last;
    bit               settled;
    if (win_len == 0) begin
      span = 1;
    end else if (win_len > MAX_WINDOW) begin
      span = POS_W'(MAX_WINDOW);
    end else begin
      span = POS_W'(win_len);
    end
    if (new_seq) clear_window();
    pos = pos_ctr;
    // drop head candidates that have aged out; a shrunk window may retire several
    settled = 1'b0;
    while (occupancy != 0 && !settled) begin
      age = pos - cand_pos[head_ptr];
      if (age < span) begin
        settled = 1'b1;
      end else begin
        head_ptr++;
        occupancy--;
      end
    end
    // drop tail candidates the new sample strictly beats; ties stay
    settled = 1'b0;
    while (occupancy != 0 && !settled) begin
      last = tail_ptr - 1'b1;
      if (track_min ? (cand_val[last] > smp) : (cand_val[last] < smp)) begin
        tail_ptr = last;
        occupancy--;
      end else begin
        settled = 1'b1;
      end
    end
    // full deque gives up its head
    if (occupancy >= MAX_WINDOW) begin
      head_ptr++;
      occupancy--;
    end
    cand_val[tail_ptr] = smp;
    cand_pos[tail_ptr] = pos;
    tail_ptr++;
    occupancy++;
    pos_ctr = pos + 1'b1;
    if (seen_cnt < span) seen_cnt++;
    extreme = cand_val[head_ptr];
    return seen_cnt >= span;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : score
    sample_t expected;
    sample_t got;
    bit      emits;
    if (!rst_ni) begin
      clear_window();
      win_len   = WINDOW_SIZE_RST;
      track_min = 1'b0;
      extremes_due.delete();
      fail_cnt  = 0;
      checked   = 0;
      fail_cnt_o <= 0;
      pending_o  <= 0;
      checked_o  <= 0;
    end else begin
      // follow register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WINDOW_SIZE:  win_len   = cfg_data_i[WINDOW_SIZE_W-1:0];
          CFG_FIND_MINIMUM: track_min = cfg_data_i[0];
          default: ;
        endcase
      end
      // score a result beat against the oldest prediction
      if (ext_ch_i.valid && ext_ch_i.ready) begin
        got = ext_ch_i.window_extreme;
        checked++;
        if (extremes_due.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_LIMIT)
            $display("%0t: window extreme %0d arrived with none expected", $time, got);
        end else begin
          expected = extremes_due[0];
          extremes_due.delete(0);
          if (got !== expected) begin
            fail_cnt++;
            if (fail_cnt <= REPORT_LIMIT)
              $display("%0t: window extreme mismatch: expected %0d, got %0d",
                       $time, expected, got);
          end
        end
      end
      // predict from a sample beat
      if (smp_ch_i.valid && smp_ch_i.ready) begin
        emits = slide_window(smp_ch_i.sample, smp_ch_i.restart, expected);
        if (emits) extremes_due = {extremes_due, expected};
      end
      fail_cnt_o <= fail_cnt;
      pending_o  <= extremes_due.size();
      checked_o  <= checked;
    end
  end

endmodule

[tb/sv/testbench.sv]
// Top of the sliding-window extreme testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  import swe_pkg::*;

  localparam int SW            = SAMPLE_WIDTH_DEF;
  localparam int MW            = MAX_WINDOW_DEF;
  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 300;
  localparam int LONG_HOLD     = 400;
  localparam int LIMIT_CYCLES  = 1_000_000;

  typedef logic signed [SW-1:0] sample_t;
  typedef enum logic [1:0] {RUN_NOISE, RUN_TIES, RUN_FALL, RUN_RISE} run_kind_e;

  localparam sample_t S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam sample_t S_MIN = {1'b1, {(SW-1){1'b0}}};

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_cnt;
  int pending;
  int checked;

  // Stimulus state
  bit        burst     = 1'b0;
  bit        hold_req  = 1'b0;
  int        cur_span  = 1;
  int        sent_cnt  = 0;
  int        restart_cnt = 0;
  int        setting_cnt = 0;
  sample_t   trend_val = '0;
  run_kind_e run_kind  = RUN_NOISE;
  int        run_left  = 0;

  swe_in_if  #(.SAMPLE_WIDTH(SW)) smp_ch ();
  swe_out_if #(.SAMPLE_WIDTH(SW)) ext_ch ();

  sliding_window_extreme_unit #(
    .MAX_WINDOW  (MW),
    .SAMPLE_WIDTH(SW)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (smp_ch),
    .out_o     (ext_ch)
  );

  swe_extreme_checker #(
    .MAX_WINDOW  (MW),
    .SAMPLE_WIDTH(SW)
  ) u_chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .smp_ch_i  (smp_ch),
    .ext_ch_i  (ext_ch),
    .fail_cnt_o(fail_cnt),
    .pending_o (pending),
    .checked_o (checked)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Idle lengths: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Samples come in runs: noise, near-ties, falling and rising ramps
  function automatic sample_t next_sample();
    if (run_left == 0) begin
      run_kind = run_kind_e'($urandom_range(0, 3));
      run_left = $urandom_range(1, 2 * cur_span + 4);
    end
    run_left--;
    case (run_kind)
      RUN_NOISE: begin
        if ($urandom_range(0, 7) == 0) trend_val = $urandom_range(0, 1) ? S_MAX : S_MIN;
        else trend_val = sample_t'($urandom());
      end
      RUN_TIES: trend_val = sample_t'($urandom_range(0, 6)) - sample_t'(3);
      RUN_FALL: trend_val = trend_val - sample_t'($urandom_range(0, 3));
      default:  trend_val = trend_val + sample_t'($urandom_range(0, 3));
    endcase
    return trend_val;
  endfunction

  task automatic send_sample(input sample_t value, input logic new_seq);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      smp_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    smp_ch.valid   <= 1'b1;
    smp_ch.sample  <= value;
    smp_ch.restart <= new_seq;
    @(posedge clk_i);
    while (!smp_ch.ready) @(posedge clk_i);
    sent_cnt++;
    if (new_seq) restart_cnt++;
  endtask

  // Write both registers on back-to-back edges
  task automatic program_window(input logic [WINDOW_SIZE_W-1:0] win, input logic find_min);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_WINDOW_SIZE;
    cfg_data <= CFG_DATA_W'(win);
    @(posedge clk_i);
    cfg_idx  <= CFG_FIND_MINIMUM;
    cfg_data <= CFG_DATA_W'(find_min);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    if (win == 0) cur_span = 1;
    else if (win > MW) cur_span = MW;
    else cur_span = int'(win);
    setting_cnt++;
  endtask

  task automatic await_drain();
    smp_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Drain, then let a sample with no result finish before touching registers
  task automatic settle();
    await_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic stream_phase(input int n_items, input int hold_at, input int pause_at);
    for (int i = 0; i < n_items; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      if (i == pause_at) await_drain();
      send_sample(next_sample(), $urandom_range(0, 4 * cur_span + 8) == 0);
    end
  endtask

  // Result side: random back-pressure, plus a long hold-off on request
  initial begin : sink_proc
    ext_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        ext_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        int stall;
        stall = pick_gap();
        if (stall > 0) begin
          ext_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      ext_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stim_proc
    rst_ni         <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_idx        <= CFG_WINDOW_SIZE;
    cfg_data       <= '0;
    smp_ch.valid   <= 1'b0;
    smp_ch.sample  <= '0;
    smp_ch.restart <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extremes of the sample range and equal values, window of three, maximum
    program_window(3, 1'b0);
    send_sample(S_MAX, 1'b1);
    send_sample(S_MIN, 1'b0);
    send_sample(0, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(5, 1'b0);
    send_sample(5, 1'b0);
    send_sample(5, 1'b0);
    send_sample(3, 1'b0);
    // Falling run keeps all four samples as candidates, then a shrink to one drops several heads
    settle();
    program_window(4, 1'b0);
    send_sample(9, 1'b1);
    send_sample(8, 1'b0);
    send_sample(7, 1'b0);
    send_sample(6, 1'b0);
    settle();
    program_window(1, 1'b0);
    send_sample(0, 1'b0);
    send_sample(2, 1'b0);
    // Grow mid-sequence: results resume once the count reaches six
    settle();
    program_window(6, 1'b0);
    send_sample(-4, 1'b0);
    send_sample(1, 1'b0);
    send_sample(S_MIN, 1'b0);
    // Zero length acts as one, minimum mode
    settle();
    program_window(0, 1'b1);
    send_sample(-5, 1'b1);
    send_sample(S_MIN, 1'b0);
    send_sample(S_MAX, 1'b0);
    // Length past the deque depth is clamped
    settle();
    program_window(127, 1'b1);
    send_sample(S_MAX, 1'b1);
    send_sample(S_MIN, 1'b0);
    send_sample(7, 1'b0);

    // Random phases across lengths and modes
    settle();
    program_window(1, 1'b0);
    stream_phase(80, -1, -1);
    settle();
    program_window(64, 1'b0);
    stream_phase(200, 100, -1);
    settle();
    program_window(64, 1'b1);
    stream_phase(160, -1, 80);
    settle();
    program_window(0, 1'b1);
    stream_phase(60, -1, -1);
    settle();
    program_window(127, 1'b0);
    stream_phase(120, -1, -1);
    settle();
    program_window(2, 1'b1);
    stream_phase(80, 40, -1);
    settle();
    burst = 1'b1;
    program_window(WINDOW_SIZE_W'($urandom_range(3, 63)), 1'b0);
    stream_phase(100, -1, -1);
    settle();
    burst = 1'b0;
    program_window(WINDOW_SIZE_W'($urandom_range(3, 63)), 1'b1);
    stream_phase(100, -1, -1);
    settle();
    program_window(17, 1'b0);
    stream_phase(80, -1, 40);
    settle();

    $display("streamed %0d samples (%0d restarts) over %0d window settings, max and min",
             sent_cnt, restart_cnt, setting_cnt);
    $display("compared %0d window extremes, %0d failures", checked, fail_cnt);
    if (pending != 0) $display("%0d window extremes never arrived", pending);
    if (fail_cnt == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
